[rtl/core/relay_scanner_switch_sequencer_unit_defines.svh]
// Assertion macros shared by the relay scanner sequencer RTL.
// Depends on nothing; the using module must have clk and rst in scope.
`ifndef RELAY_SCANNER_SWITCH_SEQUENCER_UNIT_DEFINES_SVH
`define RELAY_SCANNER_SWITCH_SEQUENCER_UNIT_DEFINES_SVH

// Same-cycle implication, checked at every rising edge outside reset.
`define RSSU_ASSERT_NOW(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, checked at every rising edge outside reset.
`define RSSU_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

[rtl/core/rssu_pkg.sv]
// Shared types, codes and helper functions of the relay scanner sequencer.
// Depends on nothing; every other RTL module of the block uses it.
package rssu_pkg;

  // Channel count and plan sizes.
  localparam int NumChannelsDefault = 16;
  localparam int MaxOps             = 5;
  localparam int OpIdxW             = $clog2(MaxOps + 1);
  localparam int QueueDepth         = 2;

  // Expander bus constants.
  localparam logic [5:0] ExpBase       = 6'h20;
  localparam logic [5:0] ChipHiAddr    = 6'h04;
  localparam logic [1:0] RegOut0       = 2'h2;
  localparam logic [1:0] RegOut1       = 2'h3;
  localparam logic [7:0] CombinePin    = 8'h02;
  localparam logic [3:0] PartnerOffset = 4'd8;

  // Configuration register indexes.
  localparam logic [1:0] CfgMakeBeforeBreak = 2'd0;
  localparam logic [1:0] CfgPulseTicks      = 2'd1;
  localparam logic [1:0] CfgDebounceTicks   = 2'd2;

  // Reset values of the configuration registers.
  localparam logic [7:0] PulseTicksReset    = 8'd4;
  localparam logic [7:0] DebounceTicksReset = 8'd3;

  typedef enum logic [1:0] {
    KIND_SELECT = 2'd0,
    KIND_OPEN   = 2'd1,
    KIND_MODE   = 2'd2
  } kind_t;

  typedef enum logic [1:0] {
    ACT_STATUS = 2'd0,
    ACT_WRITE  = 2'd1,
    ACT_WAIT   = 2'd2
  } act_t;

  typedef enum logic {
    OP_PULSE = 1'b0,
    OP_WAIT  = 1'b1
  } op_kind_t;

  // Steps of one relay pulse in the back end.
  typedef enum logic [1:0] {
    SUB_SET   = 2'd0,
    SUB_HOLD  = 2'd1,
    SUB_CLEAR = 2'd2
  } sub_t;

  // One planned operation: a coil pulse or a debounce wait.
  typedef struct packed {
    op_kind_t    kind;
    logic        hi;       // chip 4 when set, chip 0 otherwise
    logic        port;
    logic [7:0]  pattern;
  } op_t;

  // Relay state after a command.
  typedef struct packed {
    logic       any_closed;
    logic [3:0] closed_channel;
    logic       four_wire;
  } snap_t;

  // One classified command as handed from front to back.
  typedef struct packed {
    op_t [MaxOps-1:0]  ops;
    logic [OpIdxW-1:0] n_ops;
    snap_t             snap;
  } desc_t;

  // Timing configuration seen by the back end.
  typedef struct packed {
    logic       make_before_break;
    logic [7:0] pulse_ticks;
    logic [7:0] debounce_ticks;
  } timing_t;

  // One result item.
  typedef struct packed {
    act_t       action;
    logic [5:0] bus_address;
    logic [1:0] register_index;
    logic [7:0] data_byte;
    logic [7:0] wait_ticks;
    logic       last;
    snap_t      snap;
  } res_t;

  // Pulse on a channel relay: close drives its pin, open drives the others.
  function automatic op_t chan_op(input logic [3:0] idx, input logic closing);
    op_t        op;
    logic [7:0] pin;
    pin        = 8'b1 << idx[2:0];
    op.kind    = OP_PULSE;
    op.hi      = ~idx[3];
    op.port    = idx[2];
    op.pattern = closing ? pin : ~pin;
    return op;
  endfunction

  // Pulse on the combine relay that follows the four-wire mode.
  function automatic op_t combine_op(input logic en);
    op_t op;
    op.kind    = OP_PULSE;
    op.hi      = 1'b1;
    op.port    = 1'b1;
    op.pattern = en ? CombinePin : ~CombinePin;
    return op;
  endfunction

  function automatic op_t wait_op();
    op_t op;
    op.kind    = OP_WAIT;
    op.hi      = 1'b0;
    op.port    = 1'b0;
    op.pattern = 8'h00;
    return op;
  endfunction

endpackage

[rtl/core/rssu_front.sv]
// Front end: configuration registers, relay state and command planning.
// Depends on rssu_pkg; feeds one plan per accepted item into the queue.
module rssu_front #(
  parameter int NUM_CHANNELS = rssu_pkg::NumChannelsDefault
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              cfg_we,
  input  logic [1:0]        cfg_index,
  input  logic [7:0]        cfg_data,
  input  logic              push,
  input  logic              q_full,
  input  logic [1:0]        kind,
  input  logic [4:0]        channel,
  input  logic              enable,
  output logic              q_push,
  output rssu_pkg::desc_t   q_desc,
  output rssu_pkg::timing_t timing
);

  localparam logic [4:0] ChanLimit = 5'(NUM_CHANNELS);
  localparam logic [4:0] ChanHalf  = 5'(NUM_CHANNELS / 2);

  logic       closed_valid, closed_valid_next;
  logic [3:0] closed_index, closed_index_next;
  logic       four_wire, four_wire_next;

  rssu_pkg::op_t [rssu_pkg::MaxOps-1:0] ops;
  logic [rssu_pkg::OpIdxW-1:0]          op_cnt;
  rssu_pkg::op_t                        old_open, old_partner;
  logic [4:0]                           ch_eff;
  logic [3:0]                           ch4;

  // Configuration registers: the user must write them only while the block is idle; the block does not enforce this.
  always_ff @(posedge clk) begin
    if (rst) begin
      timing.make_before_break <= 1'b0;
      timing.pulse_ticks       <= rssu_pkg::PulseTicksReset;
      timing.debounce_ticks    <= rssu_pkg::DebounceTicksReset;
    end else if (cfg_we) begin
      if (cfg_index == rssu_pkg::CfgMakeBeforeBreak) begin
        timing.make_before_break <= cfg_data[0];
      end
      if (cfg_index == rssu_pkg::CfgPulseTicks) begin
        timing.pulse_ticks <= cfg_data;
      end
      if (cfg_index == rssu_pkg::CfgDebounceTicks) begin
        timing.debounce_ticks <= cfg_data;
      end
    end
  end

  assign q_push = push && !q_full;

  // Plan the operations of one command and the state it leaves behind.
  always_comb begin
    ops               = '0;
    op_cnt            = '0;
    closed_valid_next = closed_valid;
    closed_index_next = closed_index;
    four_wire_next    = four_wire;
    old_open          = rssu_pkg::chan_op(closed_index, 1'b0);
    old_partner       = rssu_pkg::chan_op(closed_index + rssu_pkg::PartnerOffset, 1'b0);
    // In four-wire mode the upper half of the channels folds onto the lower.
    ch_eff = (four_wire && channel >= ChanHalf) ? (channel >> 1) : channel;
    ch4    = ch_eff[3:0];

    unique case (rssu_pkg::kind_t'(kind))
      rssu_pkg::KIND_SELECT: begin
        if (channel < ChanLimit && !(closed_valid && closed_index == ch4)) begin
          // Break before make: open the old channel and settle first.
          if (!timing.make_before_break) begin
            if (closed_valid) begin
              ops[op_cnt] = old_open;
              op_cnt      = op_cnt + 1'b1;
              if (four_wire) begin
                ops[op_cnt] = old_partner;
                op_cnt      = op_cnt + 1'b1;
              end
            end
            ops[op_cnt] = rssu_pkg::wait_op();
            op_cnt      = op_cnt + 1'b1;
          end
          if (four_wire) begin
            ops[op_cnt] = rssu_pkg::chan_op(ch4 + rssu_pkg::PartnerOffset, 1'b1);
            op_cnt      = op_cnt + 1'b1;
          end
          ops[op_cnt] = rssu_pkg::chan_op(ch4, 1'b1);
          op_cnt      = op_cnt + 1'b1;
          // Make before break: settle, then open the old channel.
          if (timing.make_before_break) begin
            ops[op_cnt] = rssu_pkg::wait_op();
            op_cnt      = op_cnt + 1'b1;
            if (closed_valid) begin
              ops[op_cnt] = old_open;
              op_cnt      = op_cnt + 1'b1;
              if (four_wire) begin
                ops[op_cnt] = old_partner;
                op_cnt      = op_cnt + 1'b1;
              end
            end
          end
          closed_valid_next = 1'b1;
          closed_index_next = ch4;
        end
      end
      rssu_pkg::KIND_OPEN: begin
        if (closed_valid) begin
          ops[op_cnt] = old_open;
          op_cnt      = op_cnt + 1'b1;
          if (four_wire) begin
            ops[op_cnt] = old_partner;
            op_cnt      = op_cnt + 1'b1;
          end
        end
        closed_valid_next = 1'b0;
      end
      rssu_pkg::KIND_MODE: begin
        if (enable != four_wire) begin
          if (closed_valid) begin
            ops[op_cnt] = old_open;
            op_cnt      = op_cnt + 1'b1;
            if (four_wire) begin
              ops[op_cnt] = old_partner;
              op_cnt      = op_cnt + 1'b1;
            end
          end
          ops[op_cnt] = rssu_pkg::wait_op();
          op_cnt      = op_cnt + 1'b1;
          ops[op_cnt] = rssu_pkg::combine_op(enable);
          op_cnt      = op_cnt + 1'b1;
          closed_valid_next = 1'b0;
          four_wire_next    = enable;
        end
      end
      default: begin
        // The unused kind only reports status.
      end
    endcase

    q_desc.ops                 = ops;
    q_desc.n_ops               = op_cnt;
    q_desc.snap.any_closed     = closed_valid_next;
    q_desc.snap.closed_channel = closed_valid_next ? closed_index_next : 4'd0;
    q_desc.snap.four_wire      = four_wire_next;
  end

  // Relay state moves on as soon as an item is planned.
  always_ff @(posedge clk) begin
    if (rst) begin
      closed_valid <= 1'b0;
      closed_index <= 4'd0;
      four_wire    <= 1'b0;
    end else if (q_push) begin
      closed_valid <= closed_valid_next;
      closed_index <= closed_index_next;
      four_wire    <= four_wire_next;
    end
  end

endmodule

[rtl/core/rssu_queue.sv]
// Short plan queue between the front and back ends of the sequencer.
// Depends on rssu_pkg for the plan type and its depth.
module rssu_queue (
  input  logic            clk,
  input  logic            rst,
  input  logic            wr,
  input  rssu_pkg::desc_t wr_data,
  output logic            full,
  input  logic            rd,
  output logic            rd_valid,
  output rssu_pkg::desc_t rd_data
);

  localparam int PtrW = $clog2(rssu_pkg::QueueDepth);
  localparam int CntW = $clog2(rssu_pkg::QueueDepth + 1);
  localparam logic [CntW-1:0] DepthCnt = CntW'(rssu_pkg::QueueDepth);
  localparam logic [PtrW-1:0] LastPtr  = PtrW'(rssu_pkg::QueueDepth - 1);

  rssu_pkg::desc_t entries [rssu_pkg::QueueDepth];
  logic [PtrW-1:0] wr_ptr, rd_ptr;
  logic [CntW-1:0] count;

  assign full     = (count == DepthCnt);
  assign rd_valid = (count != '0);
  assign rd_data  = entries[rd_ptr];

  // Entry storage.
  always_ff @(posedge clk) begin
    if (wr) begin
      entries[wr_ptr] <= wr_data;
    end
  end

  // Pointers and fill count.
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (wr) begin
        wr_ptr <= (wr_ptr == LastPtr) ? '0 : wr_ptr + 1'b1;
      end
      if (rd) begin
        rd_ptr <= (rd_ptr == LastPtr) ? '0 : rd_ptr + 1'b1;
      end
      if (wr && !rd) begin
        count <= count + 1'b1;
      end else if (rd && !wr) begin
        count <= count - 1'b1;
      end
    end
  end

endmodule

[rtl/core/rssu_back.sv]
// Back end: expands each plan into write, wait and status items.
// Depends on rssu_pkg and the assertion macros header.
`include "relay_scanner_switch_sequencer_unit_defines.svh"

module rssu_back (
  input  logic              clk,
  input  logic              rst,
  input  rssu_pkg::timing_t timing,
  input  logic              q_valid,
  input  rssu_pkg::desc_t   q_desc,
  output logic              q_pop,
  input  logic              pop,
  output logic              empty,
  output rssu_pkg::res_t    res
);

  localparam logic [rssu_pkg::OpIdxW-1:0] LastOp = rssu_pkg::OpIdxW'(rssu_pkg::MaxOps - 1);

  rssu_pkg::sub_t              sub, sub_next;
  logic [rssu_pkg::OpIdxW-1:0] op_idx, op_idx_next;
  logic [rssu_pkg::OpIdxW-1:0] op_sel;
  rssu_pkg::op_t               cur_op;
  rssu_pkg::res_t              res_next;
  logic                        out_valid;
  logic                        adv, issue, is_status;
  logic [5:0]                  op_addr;
  logic [1:0]                  op_reg;

  assign empty     = !out_valid;
  assign adv       = !out_valid || pop;
  assign issue     = adv && q_valid;
  assign is_status = (op_idx == q_desc.n_ops);
  assign op_sel    = (op_idx > LastOp) ? LastOp : op_idx;
  assign cur_op    = q_desc.ops[op_sel];
  assign op_addr   = rssu_pkg::ExpBase | (cur_op.hi ? rssu_pkg::ChipHiAddr : 6'h00);
  assign op_reg    = cur_op.port ? rssu_pkg::RegOut1 : rssu_pkg::RegOut0;

  // Step state: current op of the head plan and the step within a pulse.
  always_ff @(posedge clk) begin
    if (rst) begin
      sub    <= rssu_pkg::SUB_SET;
      op_idx <= '0;
    end else begin
      sub    <= sub_next;
      op_idx <= op_idx_next;
    end
  end

  // Next step and the result item it produces.
  always_comb begin
    sub_next                = sub;
    op_idx_next             = op_idx;
    q_pop                   = 1'b0;
    res_next.action         = rssu_pkg::ACT_STATUS;
    res_next.bus_address    = 6'h00;
    res_next.register_index = 2'h0;
    res_next.data_byte      = 8'h00;
    res_next.wait_ticks     = 8'h00;
    res_next.last           = 1'b0;
    res_next.snap           = q_desc.snap;
    if (issue) begin
      if (is_status) begin
        // Closing status item; the plan leaves the queue.
        res_next.last = 1'b1;
        q_pop         = 1'b1;
        op_idx_next   = '0;
        sub_next      = rssu_pkg::SUB_SET;
      end else if (cur_op.kind == rssu_pkg::OP_WAIT) begin
        res_next.action     = rssu_pkg::ACT_WAIT;
        res_next.wait_ticks = timing.debounce_ticks;
        op_idx_next         = op_idx + 1'b1;
      end else begin
        unique case (sub)
          rssu_pkg::SUB_SET: begin
            res_next.action         = rssu_pkg::ACT_WRITE;
            res_next.bus_address    = op_addr;
            res_next.register_index = op_reg;
            res_next.data_byte      = cur_op.pattern;
            sub_next                = rssu_pkg::SUB_HOLD;
          end
          rssu_pkg::SUB_HOLD: begin
            res_next.action     = rssu_pkg::ACT_WAIT;
            res_next.wait_ticks = timing.pulse_ticks;
            sub_next            = rssu_pkg::SUB_CLEAR;
          end
          rssu_pkg::SUB_CLEAR: begin
            res_next.action         = rssu_pkg::ACT_WRITE;
            res_next.bus_address    = op_addr;
            res_next.register_index = op_reg;
            sub_next                = rssu_pkg::SUB_SET;
            op_idx_next             = op_idx + 1'b1;
          end
          default: begin
            sub_next = rssu_pkg::SUB_SET;
          end
        endcase
      end
    end
  end

  // Output register valid flag.
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (adv) begin
      out_valid <= q_valid;
    end
  end

  // Output register payload.
  always_ff @(posedge clk) begin
    if (issue) begin
      res <= res_next;
    end
  end

  // Only the status item closes a run.
  `RSSU_ASSERT_NOW(a_last_is_status, out_valid && res.last, res.action == rssu_pkg::ACT_STATUS, "last set on a non-status item")
  // A pulse in progress always belongs to a real pulse op of the head plan.
  `RSSU_ASSERT_NOW(a_pulse_step_owner, sub != rssu_pkg::SUB_SET, q_valid && (op_idx < q_desc.n_ops) && (cur_op.kind == rssu_pkg::OP_PULSE), "pulse step without a pulse op")
  // The op pointer never runs past the head plan.
  `RSSU_ASSERT_NOW(a_op_idx_bound, q_valid, op_idx <= q_desc.n_ops, "op pointer past end of plan")
  // A coil write is always followed by its hold wait.
  `RSSU_ASSERT_NEXT(a_set_then_hold, issue && !is_status && (cur_op.kind == rssu_pkg::OP_PULSE) && (sub == rssu_pkg::SUB_SET), out_valid && (res.action == rssu_pkg::ACT_WRITE) && (sub == rssu_pkg::SUB_HOLD), "coil write not followed by hold step")

endmodule

[rtl/core/relay_scanner_switch_sequencer_unit.sv]
// Relay scanner switch sequencer: each accepted command (select a channel,
// open the current channel, or set four-wire mode) becomes a run of result
// items (expander output-register writes and waits) closed by one status item
// with last set. Every item of a run carries the relay state after the command.
// A command gives 1 to 14 items at the output: the back end issues one item
// per clock through its single output register while the receiver pops. The
// front end plans a command in the cycle it is accepted, so commands enter
// back to back until the two-entry plan queue that holds them for the back end is full.
// Depends on rssu_pkg, rssu_front, rssu_queue and rssu_back.
module relay_scanner_switch_sequencer_unit #(
  parameter int NUM_CHANNELS = rssu_pkg::NumChannelsDefault
) (
  input  logic       clk,
  input  logic       rst,
  input  logic       cfg_we,
  input  logic [1:0] cfg_index,
  input  logic [7:0] cfg_data,
  input  logic       push,
  output logic       full,
  input  logic [1:0] kind,
  input  logic [4:0] channel,
  input  logic       enable,
  output logic       empty,
  input  logic       pop,
  output logic [1:0] action,
  output logic [5:0] bus_address,
  output logic [1:0] register_index,
  output logic [7:0] data_byte,
  output logic [7:0] wait_ticks,
  output logic       last,
  output logic       any_closed,
  output logic [3:0] closed_channel,
  output logic       four_wire_on
);

  rssu_pkg::timing_t timing;
  rssu_pkg::desc_t   wr_desc, rd_desc;
  rssu_pkg::res_t    res;
  logic              q_push, q_pop, q_full, q_valid;

  assign full = q_full;

  // Front end: configuration, relay state and planning.
  rssu_front #(
    .NUM_CHANNELS(NUM_CHANNELS)
  ) u_front (
    .clk      (clk),
    .rst      (rst),
    .cfg_we   (cfg_we),
    .cfg_index(cfg_index),
    .cfg_data (cfg_data),
    .push     (push),
    .q_full   (q_full),
    .kind     (kind),
    .channel  (channel),
    .enable   (enable),
    .q_push   (q_push),
    .q_desc   (wr_desc),
    .timing   (timing)
  );

  // Plan queue between the two ends.
  rssu_queue u_queue (
    .clk     (clk),
    .rst     (rst),
    .wr      (q_push),
    .wr_data (wr_desc),
    .full    (q_full),
    .rd      (q_pop),
    .rd_valid(q_valid),
    .rd_data (rd_desc)
  );

  // Back end: item expansion and output register.
  rssu_back u_back (
    .clk    (clk),
    .rst    (rst),
    .timing (timing),
    .q_valid(q_valid),
    .q_desc (rd_desc),
    .q_pop  (q_pop),
    .pop    (pop),
    .empty  (empty),
    .res    (res)
  );

  // Result fields onto their ports.
  assign action         = res.action;
  assign bus_address    = res.bus_address;
  assign register_index = res.register_index;
  assign data_byte      = res.data_byte;
  assign wait_ticks     = res.wait_ticks;
  assign last           = res.last;
  assign any_closed     = res.snap.any_closed;
  assign closed_channel = res.snap.closed_channel;
  assign four_wire_on   = res.snap.four_wire;

endmodule

[bench/relay_scanner_switch_sequencer_unit_tb.sv]
// Self-checking testbench for the relay scanner switch sequencer unit.
// Depends on rssu_pkg and relay_scanner_switch_sequencer_unit; needs nothing else.
`timescale 1ns / 1ps

module relay_scanner_switch_sequencer_unit_tb;

  localparam int          NumChannels   = rssu_pkg::NumChannelsDefault;
  localparam logic [1:0]  KindSpare     = 2'd3;
  localparam int          HoldCycles    = 200;
  localparam int          WatchdogLimit = 1000;
  localparam int          ReportLimit   = 100;
  localparam int          SettleCycles  = 20;

  // One command item as offered on the input side.
  typedef struct {
    logic [1:0] kind;
    logic [4:0] channel;
    logic       enable;
  } command_t;

  // One expected action item.
  typedef struct {
    rssu_pkg::act_t action;
    logic [5:0]     addr;
    logic [1:0]     reg_idx;
    logic [7:0]     data;
    logic [7:0]     ticks;
    logic           last;
    logic           any_closed;
    logic [3:0]     closed_ch;
    logic           four_wire;
  } action_rec_t;

  logic       clk = 1'b0;
  logic       rst = 1'b1;
  logic       cfg_we = 1'b0;
  logic [1:0] cfg_index = 2'd0;
  logic [7:0] cfg_data = 8'd0;
  logic       push = 1'b0;
  logic       full;
  logic [1:0] kind = 2'd0;
  logic [4:0] channel = 5'd0;
  logic       enable = 1'b0;
  logic       empty;
  logic       pop = 1'b0;
  logic [1:0] action;
  logic [5:0] bus_address;
  logic [1:0] register_index;
  logic [7:0] data_byte;
  logic [7:0] wait_ticks;
  logic       last;
  logic       any_closed;
  logic [3:0] closed_channel;
  logic       four_wire_on;

  relay_scanner_switch_sequencer_unit u_dut (
    .clk            (clk),
    .rst            (rst),
    .cfg_we         (cfg_we),
    .cfg_index      (cfg_index),
    .cfg_data       (cfg_data),
    .push           (push),
    .full           (full),
    .kind           (kind),
    .channel        (channel),
    .enable         (enable),
    .empty          (empty),
    .pop            (pop),
    .action         (action),
    .bus_address    (bus_address),
    .register_index (register_index),
    .data_byte      (data_byte),
    .wait_ticks     (wait_ticks),
    .last           (last),
    .any_closed     (any_closed),
    .closed_channel (closed_channel),
    .four_wire_on   (four_wire_on)
  );

  always #2 clk = ~clk;

  // Commands still to be offered, and actions still to arrive.
  command_t    pending_cmds[$];
  action_rec_t expected_actions[$];
  action_rec_t run_actions[$];

  // Relay state and timing settings as the sequencer should hold them.
  logic       relay_closed   = 1'b0;
  logic [3:0] relay_index    = 4'd0;
  logic       four_wire_mode = 1'b0;
  logic       mbb_cfg        = 1'b0;
  logic [7:0] pulse_cfg      = rssu_pkg::PulseTicksReset;
  logic [7:0] debounce_cfg   = rssu_pkg::DebounceTicksReset;

  // Traffic shaping, set between phases on the falling edge.
  int unsigned sender_idle_pct = 0;
  int unsigned recv_idle_pct   = 0;
  logic        holdoff_request = 1'b0;
  logic        holdoff_taken   = 1'b0;
  int unsigned hold_count      = 0;
  int unsigned fail_count      = 0;
  int unsigned quiet_cycles    = 0;

  function automatic void add_action(rssu_pkg::act_t act, logic [5:0] addr,
                                     logic [1:0] reg_idx, logic [7:0] data,
                                     logic [7:0] ticks);
    action_rec_t rec;
    rec.action     = act;
    rec.addr       = addr;
    rec.reg_idx    = reg_idx;
    rec.data       = data;
    rec.ticks      = ticks;
    rec.last       = 1'b0;
    rec.any_closed = 1'b0;
    rec.closed_ch  = 4'd0;
    rec.four_wire  = 1'b0;
    run_actions.push_back(rec);
  endfunction

  // A coil pulse: drive the pattern, hold for the pulse time, release.
  function automatic void add_pulse(logic chip_hi, logic port, logic [7:0] pattern);
    logic [5:0] addr;
    logic [1:0] reg_idx;
    addr    = rssu_pkg::ExpBase | (chip_hi ? rssu_pkg::ChipHiAddr : 6'h00);
    reg_idx = port ? rssu_pkg::RegOut1 : rssu_pkg::RegOut0;
    add_action(rssu_pkg::ACT_WRITE, addr, reg_idx, pattern, 8'd0);
    add_action(rssu_pkg::ACT_WAIT, 6'd0, 2'd0, 8'd0, pulse_cfg);
    add_action(rssu_pkg::ACT_WRITE, addr, reg_idx, 8'd0, 8'd0);
  endfunction

  // Channels 0..7 sit on the high chip; closing drives one pin, opening the rest.
  function automatic void add_channel_pulse(logic [3:0] idx, logic closing);
    logic [7:0] pin;
    pin = 8'b1 << idx[2:0];
    add_pulse(~idx[3], idx[2], closing ? pin : ~pin);
  endfunction

  function automatic void add_open_current();
    if (!relay_closed) return;
    add_channel_pulse(relay_index, 1'b0);
    if (four_wire_mode) add_channel_pulse(relay_index + rssu_pkg::PartnerOffset, 1'b0);
    relay_closed = 1'b0;
  endfunction

  // Works out the action run of one accepted command and queues it.
  function automatic void predict_command(command_t cmd);
    int unsigned ch;
    ch = 32'(cmd.channel);
    run_actions.delete();
    if (cmd.kind == rssu_pkg::KIND_SELECT) begin
      if (ch < NumChannels) begin
        if (four_wire_mode && ch >= NumChannels / 2) ch = ch / 2;
        if (!(relay_closed && relay_index == ch[3:0])) begin
          if (!mbb_cfg) begin
            add_open_current();
            add_action(rssu_pkg::ACT_WAIT, 6'd0, 2'd0, 8'd0, debounce_cfg);
          end
          if (four_wire_mode) add_channel_pulse(ch[3:0] + rssu_pkg::PartnerOffset, 1'b1);
          add_channel_pulse(ch[3:0], 1'b1);
          if (mbb_cfg) begin
            add_action(rssu_pkg::ACT_WAIT, 6'd0, 2'd0, 8'd0, debounce_cfg);
            add_open_current();
          end
          relay_closed = 1'b1;
          relay_index  = ch[3:0];
        end
      end
    end else if (cmd.kind == rssu_pkg::KIND_OPEN) begin
      add_open_current();
    end else if (cmd.kind == rssu_pkg::KIND_MODE) begin
      if (cmd.enable != four_wire_mode) begin
        add_open_current();
        add_action(rssu_pkg::ACT_WAIT, 6'd0, 2'd0, 8'd0, debounce_cfg);
        four_wire_mode = cmd.enable;
        add_pulse(1'b1, 1'b1, cmd.enable ? rssu_pkg::CombinePin : ~rssu_pkg::CombinePin);
      end
    end
    add_action(rssu_pkg::ACT_STATUS, 6'd0, 2'd0, 8'd0, 8'd0);
    run_actions[run_actions.size() - 1].last = 1'b1;
    // Every item of the run carries the relay state after the command.
    foreach (run_actions[i]) begin
      run_actions[i].any_closed = relay_closed;
      run_actions[i].closed_ch  = relay_closed ? relay_index : 4'd0;
      run_actions[i].four_wire  = four_wire_mode;
      expected_actions.push_back(run_actions[i]);
    end
  endfunction

  // Reports are capped so that a badly broken block does not flood the log.
  function automatic void note_mismatch(string field, logic [7:0] want, logic [7:0] got);
    fail_count++;
    if (fail_count <= ReportLimit)
      $error("%s mismatch: expected %0d, got %0d", field, want, got);
  endfunction

  // Command driver: holds an item until it is taken, idles at random between items.
  always @(posedge clk) begin : drive_commands
    command_t next_cmd;
    if (rst) begin
      push <= 1'b0;
    end else if (!(push && full)) begin
      if (push) predict_command(pending_cmds.pop_front());
      if (pending_cmds.size() != 0 && $urandom_range(0, 99) >= sender_idle_pct) begin
        next_cmd = pending_cmds[0];
        push    <= 1'b1;
        kind    <= next_cmd.kind;
        channel <= next_cmd.channel;
        enable  <= next_cmd.enable;
      end else begin
        push <= 1'b0;
      end
    end
  end

  // Action monitor: checks each taken item against the oldest expectation.
  always @(posedge clk) begin : check_actions
    action_rec_t want;
    if (rst) begin
      pop <= 1'b0;
    end else begin
      if (pop && !empty) begin
        if (expected_actions.size() == 0) begin
          fail_count++;
          if (fail_count <= ReportLimit)
            $error("unexpected action item: action %0d last %0d", action, last);
        end else begin
          want = expected_actions.pop_front();
          if (action !== want.action) note_mismatch("action", 8'(want.action), 8'(action));
          if (bus_address !== want.addr)
            note_mismatch("bus_address", 8'(want.addr), 8'(bus_address));
          if (register_index !== want.reg_idx)
            note_mismatch("register_index", 8'(want.reg_idx), 8'(register_index));
          if (data_byte !== want.data) note_mismatch("data_byte", want.data, data_byte);
          if (wait_ticks !== want.ticks) note_mismatch("wait_ticks", want.ticks, wait_ticks);
          if (last !== want.last) note_mismatch("last", 8'(want.last), 8'(last));
          if (any_closed !== want.any_closed)
            note_mismatch("any_closed", 8'(want.any_closed), 8'(any_closed));
          if (closed_channel !== want.closed_ch)
            note_mismatch("closed_channel", 8'(want.closed_ch), 8'(closed_channel));
          if (four_wire_on !== want.four_wire)
            note_mismatch("four_wire_on", 8'(want.four_wire), 8'(four_wire_on));
        end
      end
      // A long hold-off lets the sequencer fill up and push back on its input.
      if (holdoff_request && !holdoff_taken) begin
        hold_count++;
        if (hold_count >= HoldCycles) holdoff_taken = 1'b1;
        pop <= 1'b0;
      end else begin
        pop <= ($urandom_range(0, 99) >= recv_idle_pct);
      end
    end
  end

  // Watchdog: too long without any item moving on either side ends the run.
  always @(posedge clk) begin
    if (rst || (push && !full) || (pop && !empty)) begin
      quiet_cycles = 0;
    end else begin
      quiet_cycles++;
      if (quiet_cycles >= WatchdogLimit) begin
        $display("[relay_scanner_switch_sequencer_unit] ERROR");
        $finish;
      end
    end
  end

  task automatic queue_cmd(logic [1:0] k, logic [4:0] ch, logic en);
    command_t cmd;
    cmd.kind    = k;
    cmd.channel = ch;
    cmd.enable  = en;
    pending_cmds.push_back(cmd);
  endtask

  // Mostly in-range selects, with opens, mode changes and odd items mixed in.
  task automatic queue_random_cmd();
    int unsigned pick;
    logic [4:0]  ch;
    logic        en;
    pick = $urandom_range(0, 99);
    ch   = 5'($urandom_range(0, 31));
    en   = 1'($urandom);
    if (pick < 55)
      queue_cmd(rssu_pkg::KIND_SELECT, 5'($urandom_range(0, NumChannels - 1)), en);
    else if (pick < 63)
      queue_cmd(rssu_pkg::KIND_SELECT, 5'($urandom_range(NumChannels, 31)), en);
    else if (pick < 78) queue_cmd(rssu_pkg::KIND_OPEN, ch, en);
    else if (pick < 95) queue_cmd(rssu_pkg::KIND_MODE, ch, en);
    else                queue_cmd(KindSpare, ch, en);
  endtask

  // Configuration writes happen only while nothing is in flight.
  task automatic write_reg(logic [1:0] idx, logic [7:0] value);
    @(posedge clk);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= value;
    @(posedge clk);
    cfg_we <= 1'b0;
    unique case (idx)
      rssu_pkg::CfgMakeBeforeBreak: mbb_cfg      = value[0];
      rssu_pkg::CfgPulseTicks:      pulse_cfg    = value;
      rssu_pkg::CfgDebounceTicks:   debounce_cfg = value;
      default: ;
    endcase
  endtask

  task automatic wait_drained();
    do @(negedge clk);
    while (pending_cmds.size() != 0 || push || expected_actions.size() != 0);
  endtask

  task automatic run_phase(logic mbb, logic [7:0] pulse, logic [7:0] debounce,
                           int unsigned send_pct, int unsigned recv_pct,
                           int unsigned count, logic hold);
    write_reg(rssu_pkg::CfgMakeBeforeBreak, {7'd0, mbb});
    write_reg(rssu_pkg::CfgPulseTicks, pulse);
    write_reg(rssu_pkg::CfgDebounceTicks, debounce);
    @(negedge clk);
    sender_idle_pct = send_pct;
    recv_idle_pct   = recv_pct;
    holdoff_request = hold;
    repeat (count) queue_random_cmd();
    wait_drained();
  endtask

  initial begin : run_phases
    repeat (2) @(posedge clk);
    rst <= 1'b0;

    // Directed commands under the reset timing, break-before-make.
    @(negedge clk);
    queue_cmd(rssu_pkg::KIND_SELECT, 5'd0, 1'b0);    // nothing closed yet, debounce still due
    queue_cmd(rssu_pkg::KIND_SELECT, 5'd0, 1'b0);    // already closed
    queue_cmd(rssu_pkg::KIND_SELECT, 5'd15, 1'b0);
    queue_cmd(rssu_pkg::KIND_SELECT, 5'd16, 1'b1);   // out of range
    queue_cmd(rssu_pkg::KIND_SELECT, 5'd31, 1'b0);
    queue_cmd(rssu_pkg::KIND_OPEN, 5'd0, 1'b0);
    queue_cmd(rssu_pkg::KIND_OPEN, 5'd31, 1'b1);     // nothing to open
    queue_cmd(KindSpare, 5'd31, 1'b1);               // unused kind
    queue_cmd(rssu_pkg::KIND_MODE, 5'd0, 1'b0);      // mode already in force
    queue_cmd(rssu_pkg::KIND_SELECT, 5'd4, 1'b0);
    queue_cmd(rssu_pkg::KIND_MODE, 5'd0, 1'b1);      // enter four-wire with a channel closed
    queue_cmd(rssu_pkg::KIND_MODE, 5'd7, 1'b1);
    queue_cmd(rssu_pkg::KIND_SELECT, 5'd12, 1'b0);   // high channel halved in four-wire
    queue_cmd(rssu_pkg::KIND_SELECT, 5'd8, 1'b0);
    queue_cmd(rssu_pkg::KIND_SELECT, 5'd7, 1'b1);    // partner is channel 15
    queue_cmd(rssu_pkg::KIND_SELECT, 5'd3, 1'b0);
    queue_cmd(rssu_pkg::KIND_OPEN, 5'd9, 1'b1);
    queue_cmd(rssu_pkg::KIND_SELECT, 5'd0, 1'b0);
    queue_cmd(rssu_pkg::KIND_MODE, 5'd31, 1'b0);     // leave four-wire, partner opens too
    queue_cmd(rssu_pkg::KIND_SELECT, 5'd11, 1'b0);
    queue_cmd(rssu_pkg::KIND_SELECT, 5'd5, 1'b1);
    queue_cmd(rssu_pkg::KIND_SELECT, 5'd20, 1'b0);
    wait_drained();

    // Random phases across timing settings and traffic patterns.
    run_phase(1'b1, 8'd1, 8'd0, 0, 0, 35, 1'b0);
    run_phase(1'b0, 8'd255, 8'd255, 73, 0, 35, 1'b0);
    run_phase(1'b1, 8'd0, 8'd1, 0, 73, 35, 1'b0);
    run_phase(1'b0, 8'($urandom_range(1, 255)), 8'($urandom), 15, 15, 30, 1'b0);
    run_phase(1'($urandom), 8'($urandom_range(1, 255)), 8'($urandom), 0, 0, 25, 1'b1);

    repeat (SettleCycles) @(negedge clk);
    if (fail_count == 0 && expected_actions.size() == 0) begin
      $display("[relay_scanner_switch_sequencer_unit] OK");
    end else begin
      $display("[relay_scanner_switch_sequencer_unit] ERROR");
    end
    $finish;
  end

endmodule
